FILE: sv/ifn_pkg.sv
`timescale 1ns / 1ps

package ifn_pkg;

    localparam int MAX_FRAMES     = 32768;
    localparam int SAMPLE_BITS    = 24;
    localparam int COS_TABLE_BITS = 10;

    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int QTR_W      = CNT_W - 2;
    localparam int FRAME_W    = 15;
    localparam int CFG_W      = 16;
    localparam int TABLE_SIZE = (1 << COS_TABLE_BITS) + 1;
    localparam int TIDX_W     = COS_TABLE_BITS + 1;
    localparam int GAIN_FRAC  = 30;
    localparam int GAIN_W     = GAIN_FRAC + 1;
    localparam int PROD_W     = SAMPLE_BITS + GAIN_W;
    localparam int DIVN_W     = 2 * SAMPLE_BITS;
    localparam int DCNT_W     = $clog2(SAMPLE_BITS + 1);
    localparam int MODE_W     = 2;
    localparam int STDATA_W   = ((MODE_W + 2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int MTDATA_W   = ((2 * SAMPLE_BITS + FRAME_W + 7) / 8) * 8;

    localparam longint GAIN_ONE = longint'(1) << GAIN_FRAC;
    localparam longint TARGET   = ((longint'(89) << (SAMPLE_BITS - 1)) + 50) / 100;
    localparam longint PEAK_MIN = (longint'(1) << (SAMPLE_BITS - 1)) / 1000;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 2'd0,
        MODE_PROC = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_FADE_IN  = 1'b0,
        CFG_FADE_OUT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic proc_init;
        logic rd_issue;
        logic out_load;
        logic fade_out;
        logic setup_div;
        logic dda_init;
        logic fade_rd;
        logic fade_wr;
        logic pass_clr;
        logic pass_rd;
        logic peak_upd;
        logic pass_adv;
        logic scale_sel;
        logic scl_div;
        logic scl_wr;
    } ifn_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic div_busy;
        logic fade_last;
        logic pass_last;
        logic len_zero;
        logic peak_big;
        logic readable;
        logic out_free;
    } ifn_stat_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(
        input logic signed [SAMPLE_BITS+1:0] v);
        logic signed [SAMPLE_BITS+1:0] hi;
        logic signed [SAMPLE_BITS+1:0] lo;
        hi = (SAMPLE_BITS + 2)'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
        lo = -(SAMPLE_BITS + 2)'(longint'(1) << (SAMPLE_BITS - 1));
        if (v > hi) return SAMPLE_BITS'(hi);
        if (v < lo) return SAMPLE_BITS'(lo);
        return SAMPLE_BITS'(v);
    endfunction

    function automatic logic signed [SAMPLE_BITS+1:0] apply_sign(
        input logic neg, input logic [SAMPLE_BITS:0] m);
        logic signed [SAMPLE_BITS+1:0] ext;
        ext = {1'b0, m};
        return neg ? -ext : ext;
    endfunction

    function automatic longint sin_coef(input int k);
        case (k)
            0: return 1686629713;
            1: return 693598668;
            2: return 85569306;
            3: return 5026991;
            4: return 172272;
            default: return 3864;
        endcase
    endfunction

    // sin(pi/2 * x), x in Q30
    function automatic longint sin_quarter(input longint x);
        longint x2;
        longint s;
        x2 = (x * x) >>> GAIN_FRAC;
        s  = sin_coef(5);
        for (int k = 4; k >= 0; k--) begin
            s = sin_coef(k) - ((s * x2) >>> GAIN_FRAC);
        end
        s = (s * x) >>> GAIN_FRAC;
        if (s < 0) s = 0;
        if (s > GAIN_ONE) s = GAIN_ONE;
        return s;
    endfunction

    typedef logic [GAIN_W-1:0] gain_rom_t [TABLE_SIZE];

    function automatic gain_rom_t build_gain_rom();
        gain_rom_t r;
        longint    s;
        longint    g;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            s = sin_quarter(longint'(k) << (GAIN_FRAC - COS_TABLE_BITS));
            g = (s * s) >>> GAIN_FRAC;
            if (g > GAIN_ONE) g = GAIN_ONE;
            r[k] = GAIN_W'(g);
        end
        return r;
    endfunction

    localparam gain_rom_t GAIN_ROM = build_gain_rom();

endpackage

FILE: sv/ifn_div.sv
`timescale 1ns / 1ps

module ifn_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ifn_pkg::DIVN_W-1:0]      dividend,
    input  logic [ifn_pkg::SAMPLE_BITS-1:0] divisor,
    output logic                           busy,
    output logic [ifn_pkg::SAMPLE_BITS-1:0] quotient,
    output logic [ifn_pkg::SAMPLE_BITS-1:0] remainder
);
    import ifn_pkg::*;

    // one quotient bit per cycle; upper dividend half must be below divisor
    logic                   busy_reg, busy_next;
    logic [DCNT_W-1:0]      cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] sh_reg, sh_next;
    logic [SAMPLE_BITS-1:0] dvs_reg, dvs_next;
    logic [SAMPLE_BITS:0]   trial;
    logic                   qbit;

    always_comb begin
        trial     = {rem_reg, sh_reg[SAMPLE_BITS-1]};
        qbit      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(SAMPLE_BITS);
            rem_next  = dividend[DIVN_W-1:SAMPLE_BITS];
            sh_next   = dividend[SAMPLE_BITS-1:0];
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = qbit ? SAMPLE_BITS'(trial - {1'b0, dvs_reg})
                            : SAMPLE_BITS'(trial);
            sh_next  = {sh_reg[SAMPLE_BITS-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = sh_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/ifn_dp.sv
`timescale 1ns / 1ps

module ifn_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ifn_pkg::ifn_cmd_t                cmd,
    output ifn_pkg::ifn_stat_t               stat,
    input  logic [ifn_pkg::SAMPLE_BITS-1:0]  left_in,
    input  logic [ifn_pkg::SAMPLE_BITS-1:0]  right_in,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_addr,
    input  logic [ifn_pkg::CFG_W-1:0]        cfg_wdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ifn_pkg::MTDATA_W-1:0]     m_tdata,
    output logic                            m_tlast
);
    import ifn_pkg::*;

    localparam int R_W  = QTR_W + 2;
    localparam int D2_W = QTR_W + 1;
    localparam int PAD_W = MTDATA_W - 2 * SAMPLE_BITS - FRAME_W;

    logic [2*SAMPLE_BITS-1:0] mem [MAX_FRAMES];

    logic [CFG_W-1:0]  fin_reg, fout_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rp_reg;
    logic              processed_reg;
    logic [QTR_W-1:0]  nin_reg, nout_reg;
    logic [ADDR_W-1:0] i_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;

    logic [TIDX_W-1:0] q_reg, step_q_reg;
    logic [R_W-1:0]    r_reg;
    logic [D2_W-1:0]   step_r_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic [2*SAMPLE_BITS-1:0] rd_reg;
    logic [PROD_W-1:0]        prod_l_reg, prod_r_reg;
    logic [FRAME_W-1:0]       ridx_reg;
    logic                     rlast_reg;

    logic                     mvalid_reg;
    logic [2*SAMPLE_BITS-1:0] mdata_reg;
    logic [FRAME_W-1:0]       midx_reg;
    logic                     mlast_reg;

    // load and process working values
    logic [CNT_W-1:0]  count_eff;
    logic [QTR_W-1:0]  quarter;
    logic [QTR_W-1:0]  n_cur;
    logic [D2_W-1:0]   d2;
    logic [ADDR_W-1:0] fade_addr;

    logic [SAMPLE_BITS-1:0] left_rd, right_rd, mag_l, mag_r;
    logic                   neg_l, neg_r;
    logic [GAIN_W-1:0]      op;
    logic [PROD_W:0]        rnd_l, rnd_r;
    logic [SAMPLE_BITS-1:0] fade_l, fade_r, scl_l, scl_r;

    logic                   div_start;
    logic [DIVN_W-1:0]      dvd_l, dvd_r;
    logic [SAMPLE_BITS-1:0] dvs_l;
    logic                   busy_l, busy_r;
    logic [SAMPLE_BITS-1:0] q_l, q_r, rem_l, rem_r;

    logic [R_W:0]       r_sum;
    logic [R_W-1:0]     r_next;
    logic [TIDX_W-1:0]  q_next;

    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic [2*SAMPLE_BITS-1:0] wr_data;

    always_comb begin
        count_eff = processed_reg ? '0 : count_reg;
        quarter   = QTR_W'(count_reg >> 2);
        n_cur     = cmd.fade_out ? nout_reg : nin_reg;
        d2        = {n_cur, 1'b0};
        fade_addr = cmd.fade_out
                  ? ADDR_W'(count_reg - CNT_W'(nout_reg) + CNT_W'(i_reg)) : i_reg;

        left_rd  = rd_reg[SAMPLE_BITS-1:0];
        right_rd = rd_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
        neg_l    = left_rd[SAMPLE_BITS-1];
        neg_r    = right_rd[SAMPLE_BITS-1];
        mag_l    = neg_l ? (~left_rd + 1'b1) : left_rd;
        mag_r    = neg_r ? (~right_rd + 1'b1) : right_rd;
        op       = cmd.scale_sel ? GAIN_W'(TARGET) : gain_reg;

        // round half away from zero on the magnitude
        rnd_l  = {1'b0, prod_l_reg} + (PROD_W + 1)'(longint'(1) << (GAIN_FRAC - 1));
        rnd_r  = {1'b0, prod_r_reg} + (PROD_W + 1)'(longint'(1) << (GAIN_FRAC - 1));
        fade_l = sat(apply_sign(neg_l, rnd_l[GAIN_FRAC +: SAMPLE_BITS + 1]));
        fade_r = sat(apply_sign(neg_r, rnd_r[GAIN_FRAC +: SAMPLE_BITS + 1]));
        scl_l  = sat(apply_sign(neg_l, {1'b0, q_l}));
        scl_r  = sat(apply_sign(neg_r, {1'b0, q_r}));

        div_start = cmd.setup_div | cmd.scl_div;
        dvd_l = cmd.setup_div ? DIVN_W'(longint'(1) << (COS_TABLE_BITS + 1))
                              : DIVN_W'(prod_l_reg) + DIVN_W'(peak_reg >> 1);
        dvd_r = DIVN_W'(prod_r_reg) + DIVN_W'(peak_reg >> 1);
        dvs_l = cmd.setup_div ? SAMPLE_BITS'(d2) : peak_reg;

        // table index stepping: index = round(num * 2^B / n)
        if (!cmd.fade_out) begin
            r_sum = {1'b0, r_reg} + (R_W + 1)'(step_r_reg);
            if (r_sum >= (R_W + 1)'(d2)) begin
                r_next = R_W'(r_sum - (R_W + 1)'(d2));
                q_next = q_reg + step_q_reg + 1'b1;
            end else begin
                r_next = R_W'(r_sum);
                q_next = q_reg + step_q_reg;
            end
        end else begin
            r_sum = '0;
            if (r_reg < R_W'(step_r_reg)) begin
                r_next = r_reg + R_W'(d2) - R_W'(step_r_reg);
                q_next = q_reg - step_q_reg - 1'b1;
            end else begin
                r_next = r_reg - R_W'(step_r_reg);
                q_next = q_reg - step_q_reg;
            end
        end

        mem_we  = 1'b0;
        wr_addr = count_eff[ADDR_W-1:0];
        wr_data = {right_in, left_in};
        if (cmd.load) begin
            mem_we = (count_eff < CNT_W'(MAX_FRAMES));
        end else if (cmd.fade_wr) begin
            mem_we  = 1'b1;
            wr_addr = fade_addr;
            wr_data = {fade_r, fade_l};
        end else if (cmd.scl_wr) begin
            mem_we  = 1'b1;
            wr_addr = i_reg;
            wr_data = {scl_r, scl_l};
        end

        mem_re  = cmd.rd_issue | cmd.fade_rd | cmd.pass_rd;
        rd_addr = cmd.rd_issue ? rp_reg[ADDR_W-1:0] : (cmd.fade_rd ? fade_addr : i_reg);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[wr_addr] <= wr_data;
        if (mem_re) rd_reg <= mem[rd_addr];
        if (cmd.fade_rd) gain_reg <= GAIN_ROM[q_reg];
    end

    ifn_div u_div_l (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dvd_l),
        .divisor   (dvs_l),
        .busy      (busy_l),
        .quotient  (q_l),
        .remainder (rem_l)
    );

    ifn_div u_div_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.scl_div),
        .dividend  (dvd_r),
        .divisor   (peak_reg),
        .busy      (busy_r),
        .quotient  (q_r),
        .remainder (rem_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg       <= '0;
            fout_reg      <= '0;
            count_reg     <= '0;
            rp_reg        <= '0;
            processed_reg <= 1'b0;
            mvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == CFG_FADE_IN) fin_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == CFG_FADE_OUT) fout_reg <= cfg_wdata;

            if (cmd.load) begin
                processed_reg <= 1'b0;
                if (processed_reg) rp_reg <= '0;
                if (count_eff < CNT_W'(MAX_FRAMES)) count_reg <= count_eff + 1'b1;
                else count_reg <= count_eff;
            end
            if (cmd.proc_init) begin
                processed_reg <= 1'b1;
                rp_reg        <= '0;
            end
            if (cmd.rd_issue) rp_reg <= rp_reg + 1'b1;

            if (cmd.out_load) mvalid_reg <= 1'b1;
            else if (m_tready) mvalid_reg <= 1'b0;
        end

        prod_l_reg <= PROD_W'(mag_l) * PROD_W'(op);
        prod_r_reg <= PROD_W'(mag_r) * PROD_W'(op);

        if (cmd.proc_init) begin
            nin_reg  <= (CNT_W'(fin_reg) < CNT_W'(quarter)) ? QTR_W'(fin_reg) : quarter;
            nout_reg <= (CNT_W'(fout_reg) < CNT_W'(quarter)) ? QTR_W'(fout_reg) : quarter;
            peak_reg <= '0;
        end
        if (cmd.dda_init) begin
            step_q_reg <= TIDX_W'(q_l);
            step_r_reg <= D2_W'(rem_l);
            q_reg      <= cmd.fade_out ? TIDX_W'(longint'(1) << COS_TABLE_BITS) : '0;
            r_reg      <= R_W'(n_cur);
        end else if (cmd.fade_wr) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end

        if (cmd.dda_init || cmd.pass_clr) i_reg <= '0;
        else if (cmd.fade_wr || cmd.pass_adv || cmd.scl_wr) i_reg <= i_reg + 1'b1;

        if (cmd.peak_upd) begin
            if (mag_l >= mag_r && mag_l > peak_reg) peak_reg <= mag_l;
            else if (mag_r > peak_reg) peak_reg <= mag_r;
        end

        if (cmd.rd_issue) begin
            ridx_reg  <= FRAME_W'(rp_reg);
            rlast_reg <= (rp_reg + 1'b1 == count_reg);
        end
        if (cmd.out_load) begin
            mdata_reg <= rd_reg;
            midx_reg  <= ridx_reg;
            mlast_reg <= rlast_reg;
        end
    end

    always_comb begin
        stat.n_zero    = (n_cur == '0);
        stat.div_busy  = busy_l | busy_r;
        stat.fade_last = (i_reg == ADDR_W'(n_cur - 1'b1));
        stat.pass_last = (i_reg == ADDR_W'(count_reg - 1'b1));
        stat.len_zero  = (count_reg == '0);
        stat.peak_big  = (peak_reg > SAMPLE_BITS'(PEAK_MIN));
        stat.readable  = processed_reg && (rp_reg < count_reg);
        stat.out_free  = !mvalid_reg || m_tready;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, midx_reg, mdata_reg};
    assign m_tlast  = mlast_reg;

endmodule

FILE: sv/ifn_ctrl.sv
`timescale 1ns / 1ps

module ifn_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ifn_pkg::MODE_W-1:0] mode,
    input  ifn_pkg::ifn_stat_t         stat,
    output ifn_pkg::ifn_cmd_t          cmd
);
    import ifn_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE     = 15'b000000000000001,
        ST_RD_OUT   = 15'b000000000000010,
        ST_SETUP    = 15'b000000000000100,
        ST_DIV_WAIT = 15'b000000000001000,
        ST_FADE_RD  = 15'b000000000010000,
        ST_FADE_MUL = 15'b000000000100000,
        ST_FADE_WR  = 15'b000000001000000,
        ST_PEAK_RD  = 15'b000000010000000,
        ST_PEAK_CMP = 15'b000000100000000,
        ST_PEAK_CHK = 15'b000001000000000,
        ST_SCL_RD   = 15'b000010000000000,
        ST_SCL_MUL  = 15'b000100000000000,
        ST_SCL_DST  = 15'b001000000000000,
        ST_SCL_WAIT = 15'b010000000000000,
        ST_SCL_WR   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;   // 0 fade-in, 1 fade-out
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cmd          = '0;
        cmd.fade_out = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (mode)
                        MODE_LOAD: cmd.load = 1'b1;
                        MODE_PROC: begin
                            cmd.proc_init = 1'b1;
                            phase_next    = 1'b0;
                            state_next    = ST_SETUP;
                        end
                        MODE_READ: begin
                            if (stat.readable) begin
                                cmd.rd_issue = 1'b1;
                                state_next   = ST_RD_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SETUP: begin
                if (!stat.n_zero) begin
                    cmd.setup_div = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    cmd.pass_clr = 1'b1;
                    state_next   = ST_PEAK_RD;
                end
            end
            ST_DIV_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.dda_init = 1'b1;
                    state_next   = ST_FADE_RD;
                end
            end
            ST_FADE_RD: begin
                cmd.fade_rd = 1'b1;
                state_next  = ST_FADE_MUL;
            end
            ST_FADE_MUL: state_next = ST_FADE_WR;
            ST_FADE_WR: begin
                cmd.fade_wr = 1'b1;
                if (!stat.fade_last) begin
                    state_next = ST_FADE_RD;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                    state_next = ST_SETUP;
                end else begin
                    cmd.pass_clr = 1'b1;
                    state_next   = ST_PEAK_RD;
                end
            end
            ST_PEAK_RD: begin
                if (stat.len_zero) begin
                    state_next = ST_PEAK_CHK;
                end else begin
                    cmd.pass_rd = 1'b1;
                    state_next  = ST_PEAK_CMP;
                end
            end
            ST_PEAK_CMP: begin
                cmd.peak_upd = 1'b1;
                cmd.pass_adv = 1'b1;
                state_next   = stat.pass_last ? ST_PEAK_CHK : ST_PEAK_RD;
            end
            ST_PEAK_CHK: begin
                if (stat.peak_big) begin
                    cmd.pass_clr = 1'b1;
                    state_next   = ST_SCL_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCL_RD: begin
                cmd.pass_rd = 1'b1;
                state_next  = ST_SCL_MUL;
            end
            ST_SCL_MUL: begin
                cmd.scale_sel = 1'b1;
                state_next    = ST_SCL_DST;
            end
            ST_SCL_DST: begin
                cmd.scl_div = 1'b1;
                state_next  = ST_SCL_WAIT;
            end
            ST_SCL_WAIT: begin
                if (!stat.div_busy) state_next = ST_SCL_WR;
            end
            ST_SCL_WR: begin
                cmd.scl_wr = 1'b1;
                state_next = stat.pass_last ? ST_IDLE : ST_SCL_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: sv/impulse_fade_and_normalize_top.sv
`timescale 1ns / 1ps

// channel   dir  width  contents (low bit up)
// s_        in   56     tdata: mode[1:0], left_in[25:2], right_in[49:26]
// m_        out  64     tdata: left_out[23:0], right_out[47:24], frame_index[62:48]
//                       tlast: last
// cfg_      in   1+16   cfg_addr 0 fade_in_frames, 1 fade_out_frames
//
// Load accepts one frame per cycle; a read request reads the store, then loads m_ when free.
// Process: per fade, a setup divide, then a read, multiply and write step per faded frame;
// a peak search reads and compares each frame; if the peak exceeds the minimum, scaling
// uses the bit-serial divider (both channels in parallel) and the single store write port.
// Reset is synchronous, active low; store contents are undefined until loaded.
// s_tready is high only while no request is in progress.
module impulse_fade_and_normalize_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ifn_pkg::STDATA_W-1:0]    s_tdata,   // mode, left_in, right_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ifn_pkg::MTDATA_W-1:0]    m_tdata,   // left_out, right_out, frame_index
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_addr,
    input  logic [ifn_pkg::CFG_W-1:0]       cfg_wdata
);
    import ifn_pkg::*;

    ifn_cmd_t  cmd;
    ifn_stat_t stat;

    ifn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tdata[MODE_W-1:0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    ifn_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .left_in   (s_tdata[MODE_W +: SAMPLE_BITS]),
        .right_in  (s_tdata[MODE_W + SAMPLE_BITS +: SAMPLE_BITS]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: sv/ifn_chk.sv
`timescale 1ns / 1ps

module ifn_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [ifn_pkg::STDATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ifn_pkg::MTDATA_W-1:0] m_tdata,
    input logic                        m_tlast
);
    import ifn_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a read needs a store access before its result appears
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too early");

    // s_tready drops once a process request has been taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[MODE_W-1:0] == MODE_PROC |=> !s_tready)
        else $error("request taken during processing");

endmodule

bind impulse_fade_and_normalize_top ifn_chk u_chk (.*);
